@@ design/sra_pkg.sv @@
// Shared types and constants for the segment reassembly buffer.
`timescale 1ns / 1ps

package sra_pkg;

	typedef enum logic [1:0] {
		OP_HEADER = 2'd0,
		OP_DATA   = 2'd1,
		OP_STATUS = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef struct packed {
		op_t         opcode;
		logic [31:0] segment_start;
		logic [15:0] segment_length;
		logic [7:0]  data_byte;
		logic [11:0] read_index;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_value;
		logic [15:0] segment_total;
		logic [12:0] stream_length;
		logic [12:0] gap_total;
		logic        complete;
		logic        stopped;
	} result_t;

	localparam logic [7:0]  KEY_RESET     = 8'h42;
	localparam logic [15:0] SEG_TOTAL_MAX = 16'hFFFF;
	localparam int          PADDR_W       = 3;
	localparam logic        REG_XOR_KEY   = 1'b0;

endpackage

@@ design/sra_stream_if.sv @@
// Valid/ready word channel used for the item and result streams.
`timescale 1ns / 1ps

interface sra_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/sra_mem.sv @@
// Byte store with filled marks: one synchronous memory and its clearing pass.
`timescale 1ns / 1ps

module sra_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [AW-1:0] raddr,
	output logic [8:0]    rdata,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [8:0]    wdata,
	output logic          clearing
);

	logic [8:0]    mem [DEPTH];
	logic [8:0]    rdata_q;
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata    = rdata_q;
	assign clearing = clr_q;

endmodule

@@ design/sra_ctrl.sv @@
// Segment tracking, read-modify-write of filled marks and result assembly.
`timescale 1ns / 1ps

module sra_ctrl import sra_pkg::*; #(
	parameter int DEPTH   = 4096,
	parameter int MAX_SEG = 512,
	parameter int AW      = 12,
	parameter int CW      = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clearing,
	input  logic          in_valid,
	output logic          in_ready,
	input  item_t         item,
	input  logic [7:0]    xor_key,
	input  logic          out_free,
	output logic          res_valid,
	output result_t       res,
	output logic [AW-1:0] mem_raddr,
	input  logic [8:0]    mem_rdata,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [8:0]    mem_wdata
);

	logic [31:0]   start_q;
	logic [15:0]   cnt_q;
	logic [15:0]   len_q;
	logic [15:0]   segs_q;
	logic [CW-1:0] end_q;
	logic [CW-1:0] filled_q;
	logic          stop_q;

	logic          write_s1;
	logic          result_s1;
	logic          isread_s1;
	logic          inrange_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    byte_s1;

	logic          fwd_valid_q;
	logic [AW-1:0] fwd_addr_q;
	logic [7:0]    fwd_byte_q;

	logic          acc;
	logic [32:0]   pos;
	logic          pos_in;
	logic          data_ok;
	logic          hdr_over;
	logic [32:0]   seg_end;
	logic [CW-1:0] seg_end_sat;
	logic          idx_in;
	logic          fwd_hit;
	logic          old_filled;
	logic [7:0]    old_byte;
	logic [CW-1:0] gaps;

	assign in_ready    = !clearing && !result_s1 && out_free;
	assign acc         = in_valid && in_ready;
	assign pos         = {1'b0, start_q} + {17'b0, cnt_q};
	assign pos_in      = pos < 33'(DEPTH);
	assign data_ok     = !stop_q && (cnt_q < len_q);
	assign hdr_over    = item.segment_length > 16'(MAX_SEG);
	assign seg_end     = {1'b0, item.segment_start} + {17'b0, item.segment_length};
	assign seg_end_sat = (seg_end > 33'(DEPTH)) ? CW'(DEPTH) : CW'(seg_end);
	assign idx_in      = {21'b0, item.read_index} < 33'(DEPTH);
	assign mem_raddr   = (item.opcode == OP_READ) ? AW'(item.read_index) : AW'(pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			cnt_q   <= '0;
			len_q   <= '0;
			segs_q  <= '0;
			end_q   <= '0;
			stop_q  <= 1'b0;
		end else if (acc) begin
			case (item.opcode)
				OP_HEADER: begin
					if (!stop_q) begin
						if (hdr_over) begin
							stop_q <= 1'b1;
						end else begin
							start_q <= item.segment_start;
							cnt_q   <= '0;
							len_q   <= item.segment_length;
							if (segs_q != SEG_TOTAL_MAX) begin
								segs_q <= segs_q + 16'd1;
							end
							if (seg_end_sat > end_q) begin
								end_q <= seg_end_sat;
							end
						end
					end
				end
				OP_DATA: begin
					if (data_ok) begin
						cnt_q <= cnt_q + 16'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_s1    <= 1'b0;
			result_s1   <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			write_s1    <= acc && (item.opcode == OP_DATA) && data_ok && pos_in;
			result_s1   <= acc && (item.opcode == OP_STATUS || item.opcode == OP_READ);
			fwd_valid_q <= write_s1;
		end
	end

	always_ff @(posedge clk) begin
		isread_s1  <= item.opcode == OP_READ;
		inrange_s1 <= idx_in;
		addr_s1    <= mem_raddr;
		byte_s1    <= item.data_byte;
		fwd_addr_q <= addr_s1;
		fwd_byte_q <= byte_s1;
	end

	// The write of the previous word lands at the same edge as this word's read.
	assign fwd_hit    = fwd_valid_q && (fwd_addr_q == addr_s1);
	assign old_filled = fwd_hit ? 1'b1 : mem_rdata[8];
	assign old_byte   = fwd_hit ? fwd_byte_q : mem_rdata[7:0];

	assign mem_we    = write_s1;
	assign mem_waddr = addr_s1;
	assign mem_wdata = {1'b1, byte_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
		end else if (write_s1 && !old_filled) begin
			filled_q <= filled_q + CW'(1);
		end
	end

	assign gaps = (end_q > filled_q) ? (end_q - filled_q) : '0;

	assign res_valid         = result_s1;
	assign res.read_value    = (isread_s1 && inrange_s1) ? (old_byte ^ xor_key) : 8'd0;
	assign res.segment_total = segs_q;
	assign res.stream_length = 13'(end_q);
	assign res.gap_total     = 13'(gaps);
	assign res.complete      = gaps == '0;
	assign res.stopped       = stop_q;

endmodule

@@ design/segment_reassembly_xor_buffer.sv @@
// Top level: segment reassembly buffer with XOR read-out and APB key register.
//
// Words enter on the item channel and results leave on the result channel,
// both valid/ready. Header and data words cause no result; status and read
// words each cause one result word.
// Headers and data words are taken one per cycle while the item channel is
// not held. A data word reads the filled mark of its buffer position from the
// memory and writes it back in the following cycle; back-to-back writes to the
// same position are forwarded. A status or read word is registered in the
// result stage and then stored in the result register; the item channel is
// held while the result stage holds it, so no new word is taken until it moves on.
// After reset the memory is swept clear over all DEPTH entries (4096 at the
// default), one entry per cycle; no word is taken during the sweep, while
// key writes on the APB port are taken at any time.
// When the receiver stalls, the result register holds its word and the
// item channel stops once a further result could not be stored.
// The key register resets to 0x42 and sits at byte address 0.
`timescale 1ns / 1ps

module segment_reassembly_xor_buffer import sra_pkg::*; #(
	parameter int DEPTH   = 4096,
	parameter int MAX_SEG = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	sra_stream_if.sink         item,
	sra_stream_if.source       result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [7:0]    key_q;
	logic          out_valid_q;
	result_t       out_data_q;
	logic          out_free;
	logic          res_valid;
	result_t       res;
	logic          clearing;
	logic [AW-1:0] mem_raddr;
	logic [8:0]    mem_rdata;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [8:0]    mem_wdata;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_XOR_KEY) ? {24'b0, key_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= KEY_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_XOR_KEY) begin
			key_q <= pwdata[7:0];
		end
	end

	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_data_q <= res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	sra_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.raddr   (mem_raddr),
		.rdata   (mem_rdata),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.clearing(clearing)
	);

	sra_ctrl #(
		.DEPTH  (DEPTH),
		.MAX_SEG(MAX_SEG),
		.AW     (AW),
		.CW     (CW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.item     (item.data),
		.xor_key  (key_q),
		.out_free (out_free),
		.res_valid(res_valid),
		.res      (res),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata)
	);

`ifndef SYNTH
	a_result_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!out_valid_q || result.ready))
		else $error("Result word produced while the output register is occupied.");

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !item.ready)
		else $error("Item channel ready during the memory sweep.");

	a_no_write_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !mem_we)
		else $error("Memory write issued during the memory sweep.");
`endif

endmodule

@@ sim/segment_reassembly_xor_buffer_tb.sv @@
// Self-checking testbench for the segment reassembly buffer with XOR read-out.
`timescale 1ns / 1ps

module segment_reassembly_xor_buffer_tb;
	import sra_pkg::*;

	localparam int DEPTH = 4096;
	localparam int MAX_SEG = 512;
	localparam logic [PADDR_W-1:0] KEY_ADDR = {REG_XOR_KEY, 2'b00};

	class reassembly_tracker;
		logic [7:0]  store_bytes [DEPTH];
		bit          filled [DEPTH];
		logic [31:0] seg_start;
		logic [15:0] seg_bytes_taken;
		logic [15:0] seg_len;
		logic [15:0] headers_seen;
		logic [12:0] end_pos;
		logic [12:0] filled_total;
		bit          halted;
		logic [7:0]  key;
		result_t     pending_reports [$];
		int          mismatches;

		function new();
			foreach (store_bytes[i]) begin
				store_bytes[i] = 8'h00;
				filled[i] = 1'b0;
			end
			seg_start = '0;
			seg_bytes_taken = '0;
			seg_len = '0;
			headers_seen = '0;
			end_pos = '0;
			filled_total = '0;
			halted = 1'b0;
			key = KEY_RESET;
			mismatches = 0;
		endfunction

		function void flag(string what, longint want, longint got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
			end
		endfunction

		function result_t build_report(logic [7:0] value);
			result_t r;
			logic [12:0] gaps;
			gaps = (end_pos > filled_total) ? end_pos - filled_total : 13'd0;
			r.read_value = value;
			r.segment_total = headers_seen;
			r.stream_length = end_pos;
			r.gap_total = gaps;
			r.complete = (gaps == 13'd0);
			r.stopped = halted;
			return r;
		endfunction

		function void absorb_word(item_t w);
			logic [32:0] span;
			logic [32:0] pos;
			case (w.opcode)
				OP_HEADER: begin
					if (!halted) begin
						if (w.segment_length > MAX_SEG) begin
							halted = 1'b1;
						end else begin
							span = {1'b0, w.segment_start} + {17'b0, w.segment_length};
							seg_start = w.segment_start;
							seg_bytes_taken = '0;
							seg_len = w.segment_length;
							if (headers_seen != SEG_TOTAL_MAX) headers_seen++;
							if (span > 33'(DEPTH)) span = 33'(DEPTH);
							if (span[12:0] > end_pos) end_pos = span[12:0];
						end
					end
				end
				OP_DATA: begin
					if (!halted && seg_bytes_taken < seg_len) begin
						pos = {1'b0, seg_start} + {17'b0, seg_bytes_taken};
						if (pos < 33'(DEPTH)) begin
							store_bytes[pos[11:0]] = w.data_byte;
							if (!filled[pos[11:0]]) begin
								filled[pos[11:0]] = 1'b1;
								filled_total++;
							end
						end
						seg_bytes_taken++;
					end
				end
				OP_STATUS: begin
					pending_reports.push_back(build_report(8'h00));
				end
				default: begin
					pending_reports.push_back(build_report(store_bytes[w.read_index] ^ key));
				end
			endcase
		endfunction

		function void check_report(result_t got);
			result_t want;
			if (pending_reports.size() == 0) begin
				flag("result with none pending", 0, got);
				return;
			end
			want = pending_reports.pop_front();
			if (got.read_value !== want.read_value)
				flag("read_value", want.read_value, got.read_value);
			if (got.segment_total !== want.segment_total)
				flag("segment_total", want.segment_total, got.segment_total);
			if (got.stream_length !== want.stream_length)
				flag("stream_length", want.stream_length, got.stream_length);
			if (got.gap_total !== want.gap_total)
				flag("gap_total", want.gap_total, got.gap_total);
			if (got.complete !== want.complete)
				flag("complete", want.complete, got.complete);
			if (got.stopped !== want.stopped)
				flag("stopped", want.stopped, got.stopped);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	sra_stream_if #(.T(item_t))   item_if ();
	sra_stream_if #(.T(result_t)) result_if ();

	reassembly_tracker tracker = new();
	int words_sent = 0;
	int burst_left = 0;
	bit no_idle = 1'b0;

	segment_reassembly_xor_buffer #(
		.DEPTH(DEPTH),
		.MAX_SEG(MAX_SEG)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item(item_if),
		.result(result_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (result_if.valid && result_if.ready) tracker.check_report(result_if.data);
		if (item_if.valid && item_if.ready) tracker.absorb_word(item_if.data);
	end

	initial begin
		int mode;
		int mode_left;
		result_if.ready = 1'b0;
		mode = 0;
		mode_left = 0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (mode)
				0: result_if.ready <= 1'b1;
				1: result_if.ready <= ($urandom_range(0, 1) == 1);
				2: result_if.ready <= ($urandom_range(0, 7) == 0);
				default: result_if.ready <= (mode_left % 4 != 0);
			endcase
		end
	end

	function automatic item_t make_word(op_t op, logic [31:0] start, logic [15:0] len,
			logic [7:0] b, logic [11:0] idx);
		item_t w;
		w.opcode = op;
		w.segment_start = start;
		w.segment_length = len;
		w.data_byte = b;
		w.read_index = idx;
		return w;
	endfunction

	function automatic item_t noise_word();
		return make_word(op_t'($urandom_range(0, 3)), $urandom, 16'($urandom_range(0, MAX_SEG)),
			8'($urandom), 12'($urandom));
	endfunction

	function automatic item_t query_near(logic [31:0] base);
		item_t w;
		w = noise_word();
		w.opcode = ($urandom_range(0, 2) == 0) ? OP_STATUS : OP_READ;
		if ($urandom_range(0, 4) != 0) w.read_index = base[11:0] + 12'($urandom_range(0, 15));
		return w;
	endfunction

	task automatic send_word(input item_t w);
		if (!no_idle && burst_left == 0) begin
			item_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0) burst_left--;
		item_if.valid <= 1'b1;
		item_if.data <= w;
		do @(posedge clk); while (!item_if.ready);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic drain(input int settle);
		item_if.valid <= 1'b0;
		while (tracker.pending_reports.size() != 0) @(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_key(input logic [7:0] k);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= KEY_ADDR;
		pwdata <= {24'h0, k};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.key = k;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {24'h0, k}) tracker.flag("xor_key readback", k, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_segment();
		item_t w;
		logic [31:0] base;
		int len;
		int body;
		int k;
		case ($urandom_range(0, 9))
			0: base = $urandom;
			1: base = DEPTH - $urandom_range(1, 40);
			default: base = $urandom_range(0, DEPTH - 1);
		endcase
		len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, MAX_SEG) : $urandom_range(0, 12);
		w = noise_word();
		w.opcode = OP_HEADER;
		w.segment_start = base;
		w.segment_length = 16'(len);
		send_word(w);
		body = (len > 24) ? $urandom_range(1, 24) : len;
		case ($urandom_range(0, 7))
			0: body = body + $urandom_range(1, 3);
			1: body = (body > 0) ? body - 1 : 0;
			default: ;
		endcase
		for (k = 0; k < body; k++) begin
			w = noise_word();
			w.opcode = OP_DATA;
			send_word(w);
			if ($urandom_range(0, 5) == 0) send_word(query_near(base));
		end
		repeat ($urandom_range(0, 2)) send_word(query_near(base));
	endtask

	task automatic run_traffic(input int count);
		int goal;
		goal = words_sent + count;
		while (words_sent < goal) begin
			if ($urandom_range(0, 9) == 0) no_idle = !no_idle;
			if ($urandom_range(0, 99) == 0) drain(1);
			if ($urandom_range(0, 9) < 7) send_segment();
			else send_word(noise_word());
		end
	endtask

	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		item_t w;
		int k;
		item_if.valid = 1'b0;
		item_if.data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		send_word(make_word(OP_STATUS, 0, 0, 0, 0));
		send_word(make_word(OP_READ, 0, 0, 0, 12'hFFF));
		send_word(make_word(OP_DATA, 0, 0, 8'h11, 0));
		send_word(make_word(OP_HEADER, 0, 0, 0, 0));
		send_word(make_word(OP_HEADER, 0, 3, 0, 0));
		send_word(make_word(OP_DATA, 0, 0, 8'h00, 0));
		send_word(make_word(OP_DATA, 0, 0, 8'hFF, 0));
		send_word(make_word(OP_DATA, 0, 0, 8'hA5, 0));
		send_word(make_word(OP_DATA, 0, 0, 8'h99, 0));
		send_word(make_word(OP_STATUS, 0, 0, 0, 0));
		send_word(make_word(OP_READ, 0, 0, 0, 0));
		send_word(make_word(OP_HEADER, 2, 1, 0, 0));
		send_word(make_word(OP_DATA, 0, 0, 8'h5A, 0));
		send_word(make_word(OP_READ, 0, 0, 0, 2));
		send_word(make_word(OP_HEADER, 32'(DEPTH - 6), 16'(MAX_SEG), 0, 0));
		for (k = 0; k < 7; k++) send_word(make_word(OP_DATA, 0, 0, 8'(k * 37 + 1), 0));
		send_word(make_word(OP_READ, 0, 0, 0, 12'hFFF));
		send_word(make_word(OP_HEADER, 32'hFFFF_FFFF, 1, 0, 0));
		send_word(make_word(OP_DATA, 0, 0, 8'h77, 0));
		send_word(make_word(OP_STATUS, 0, 0, 0, 0));

		run_traffic(140);
		drain(8);
		write_key(8'h00);
		run_traffic(120);
		drain(8);
		write_key(8'hFF);
		run_traffic(120);
		drain(8);
		write_key(8'($urandom_range(1, 254)));
		run_traffic(120);
		drain(8);

		send_word(make_word(OP_HEADER, $urandom, 16'(MAX_SEG + 1), 0, 0));
		send_word(make_word(OP_HEADER, 100, 4, 0, 0));
		send_word(make_word(OP_DATA, 0, 0, 8'hC3, 0));
		send_word(make_word(OP_STATUS, 0, 0, 0, 0));
		repeat (20) begin
			w = noise_word();
			w.segment_length = 16'($urandom);
			send_word(w);
		end
		send_word(make_word(OP_HEADER, $urandom, 16'hFFFF, 0, 0));
		send_word(make_word(OP_READ, 0, 0, 0, 12'd100));

		drain(10);
		if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
